### rtl/core/lfcp_pkg.sv
// lfcp_pkg: shared constants, codes and the frame record for the length framed parser
// no dependencies; used by every module of the block by scoped name
package lfcp_pkg;

    // payload bytes held per frame (four of them go out)
    localparam int KEPT_BYTES = 4;
    localparam int KEPT_IDX_W = (KEPT_BYTES > 1) ? $clog2(KEPT_BYTES) : 1;

    // queue between parser and gain stage
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int GAIN_W = 19;

    // framing characters
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LT   = 8'h3C;

    // descriptors with a known gain scale
    localparam logic [7:0] DESC_P  = 8'h50;
    localparam logic [7:0] DESC_LP = 8'h70;
    localparam logic [7:0] DESC_D  = 8'h64;

    typedef logic [1:0] t_gain_kind;
    localparam t_gain_kind KIND_OTHER = 2'd0;
    localparam t_gain_kind KIND_P     = 2'd1;
    localparam t_gain_kind KIND_LP    = 2'd2;
    localparam t_gain_kind KIND_D     = 2'd3;

    typedef struct packed {
        logic [7:0]  descriptor;
        logic [15:0] length;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        t_gain_kind  kind;
    } t_frame;

endpackage

### rtl/core/lfcp_front.sv
// lfcp_front: byte parser, header hunt, resync detector and frame capture
// depends on lfcp_pkg; pushes one finished frame record into the queue
module lfcp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_full,
    output logic            o_push,
    output lfcp_pkg::t_frame o_frame
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_STAR    = 3'd1,
        PH_GT2     = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_LEN_HI  = 3'd4,
        PH_DESC    = 3'd5,
        PH_PAYLOAD = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        RS_IDLE = 2'd0,
        RS_LT   = 2'd1,
        RS_HASH = 2'd2
    } t_resync;

    t_phase      r_phase, n_phase;
    t_resync     r_rs, n_rs;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_flen, n_flen;
    logic [7:0]  r_ftype, n_ftype;
    logic [15:0] r_cnt, n_cnt;
    logic [7:0]  r_kept [lfcp_pkg::KEPT_BYTES];
    logic [7:0]  n_kept [lfcp_pkg::KEPT_BYTES];
    logic        acc;
    logic        push;

    assign o_ready = !i_full;
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_phase  = r_phase;
        n_rs     = r_rs;
        n_len_lo = r_len_lo;
        n_flen   = r_flen;
        n_ftype  = r_ftype;
        n_cnt    = r_cnt;
        n_kept   = r_kept;
        push     = 1'b0;
        if (acc) begin
            case (r_rs)
                RS_LT: begin
                    n_rs = (i_rx_byte == lfcp_pkg::CH_HASH) ? RS_HASH : RS_IDLE;
                end
                RS_HASH: begin
                    n_rs = RS_IDLE;
                end
                default: begin
                    n_rs = (i_rx_byte == lfcp_pkg::CH_LT) ? RS_LT : RS_IDLE;
                end
            endcase

            // resync word is '<', so the hunt after the clear stays in hunt
            if ((r_rs == RS_HASH) && (i_rx_byte == lfcp_pkg::CH_LT)) begin
                n_phase  = PH_HUNT;
                n_len_lo = '0;
                n_flen   = '0;
                n_ftype  = '0;
                n_cnt    = '0;
                for (int k = 0; k < lfcp_pkg::KEPT_BYTES; k++) begin
                    n_kept[k] = '0;
                end
            end else begin
                case (r_phase)
                    PH_STAR: begin
                        n_phase = (i_rx_byte == lfcp_pkg::CH_STAR) ? PH_GT2 : PH_HUNT;
                    end
                    PH_GT2: begin
                        n_phase = (i_rx_byte == lfcp_pkg::CH_GT) ? PH_LEN_LO : PH_HUNT;
                    end
                    PH_LEN_LO: begin
                        n_len_lo = i_rx_byte;
                        n_phase  = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_flen  = {i_rx_byte, r_len_lo};
                        n_phase = PH_DESC;
                    end
                    PH_DESC: begin
                        n_ftype = i_rx_byte;
                        n_cnt   = '0;
                        n_phase = PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        if (r_cnt < r_flen) begin
                            if (r_cnt < 16'(lfcp_pkg::KEPT_BYTES)) begin
                                n_kept[r_cnt[lfcp_pkg::KEPT_IDX_W-1:0]] = i_rx_byte;
                            end
                            n_cnt = 16'(r_cnt + 16'd1);
                        end else if (i_rx_byte == lfcp_pkg::CH_HASH) begin
                            push     = 1'b1;
                            n_phase  = PH_HUNT;
                            n_len_lo = '0;
                            n_flen   = '0;
                            n_ftype  = '0;
                            n_cnt    = '0;
                            for (int k = 0; k < lfcp_pkg::KEPT_BYTES; k++) begin
                                n_kept[k] = '0;
                            end
                        end
                    end
                    default: begin
                        n_phase = (i_rx_byte == lfcp_pkg::CH_GT) ? PH_STAR : PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_rs     <= RS_IDLE;
            r_len_lo <= '0;
            r_flen   <= '0;
            r_ftype  <= '0;
            r_cnt    <= '0;
            for (int k = 0; k < lfcp_pkg::KEPT_BYTES; k++) begin
                r_kept[k] <= '0;
            end
        end else begin
            r_phase  <= n_phase;
            r_rs     <= n_rs;
            r_len_lo <= n_len_lo;
            r_flen   <= n_flen;
            r_ftype  <= n_ftype;
            r_cnt    <= n_cnt;
            r_kept   <= n_kept;
        end
    end

    // classify the descriptor while the frame still sits in the parser
    always_comb begin
        o_frame.descriptor = r_ftype;
        o_frame.length     = r_flen;
        o_frame.b0         = r_kept[0];
        o_frame.b1         = r_kept[1];
        o_frame.b2         = r_kept[2];
        o_frame.b3         = r_kept[3];
        if (r_ftype == lfcp_pkg::DESC_P) begin
            o_frame.kind = lfcp_pkg::KIND_P;
        end else if (r_ftype == lfcp_pkg::DESC_LP) begin
            o_frame.kind = lfcp_pkg::KIND_LP;
        end else if (r_ftype == lfcp_pkg::DESC_D) begin
            o_frame.kind = lfcp_pkg::KIND_D;
        end else begin
            o_frame.kind = lfcp_pkg::KIND_OTHER;
        end
    end

    assign o_push = push;

    a_push_at_frame_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_phase == PH_PAYLOAD) && (r_cnt >= r_flen)
                 && (i_rx_byte == lfcp_pkg::CH_HASH))
        else $error("frame pushed outside the end mark");

    a_count_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_cnt <= r_flen))
        else $error("payload count ran past the declared length");

endmodule

### rtl/core/lfcp_queue.sv
// lfcp_queue: short frame queue between the parser and the gain stage
// depends on lfcp_pkg for the frame record and the queue depth
module lfcp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lfcp_pkg::t_frame i_frame,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output lfcp_pkg::t_frame o_frame
);

    lfcp_pkg::t_frame                r_mem [lfcp_pkg::QUEUE_DEPTH];
    logic [lfcp_pkg::QPTR_W-1:0]     r_wr, n_wr;
    logic [lfcp_pkg::QPTR_W-1:0]     r_rd, n_rd;
    logic [lfcp_pkg::QCNT_W-1:0]     r_cnt, n_cnt;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_cnt == lfcp_pkg::QCNT_W'(lfcp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_frame = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == lfcp_pkg::QPTR_W'(lfcp_pkg::QUEUE_DEPTH - 1)) ? '0
                 : lfcp_pkg::QPTR_W'(r_wr + 1'b1);
        end
        if (do_pop) begin
            n_rd = (r_rd == lfcp_pkg::QPTR_W'(lfcp_pkg::QUEUE_DEPTH - 1)) ? '0
                 : lfcp_pkg::QPTR_W'(r_rd + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_cnt = lfcp_pkg::QCNT_W'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = lfcp_pkg::QCNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    a_cnt_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= lfcp_pkg::QCNT_W'(lfcp_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_lost_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("frame pushed into a full queue");

endmodule

### rtl/core/lfcp_back.sv
// lfcp_back: gain combination and the output register of the result channel
// depends on lfcp_pkg; pops frame records from lfcp_queue
module lfcp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  lfcp_pkg::t_frame              i_frame,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_descriptor,
    output logic [15:0]                   o_payload_length,
    output logic [7:0]                    o_payload_b0,
    output logic [7:0]                    o_payload_b1,
    output logic [7:0]                    o_payload_b2,
    output logic [7:0]                    o_payload_b3,
    output logic [lfcp_pkg::GAIN_W-1:0]   o_gain_scaled,
    output logic [1:0]                    o_gain_kind
);

    logic                         r_valid;
    logic [lfcp_pkg::GAIN_W-1:0]  gain;
    logic                         pop;

    // decimal digit weights are constants, so only shifts and adds
    assign gain = lfcp_pkg::GAIN_W'(i_frame.b0) * lfcp_pkg::GAIN_W'(1000)
                + lfcp_pkg::GAIN_W'(i_frame.b1) * lfcp_pkg::GAIN_W'(100)
                + lfcp_pkg::GAIN_W'(i_frame.b2) * lfcp_pkg::GAIN_W'(10)
                + lfcp_pkg::GAIN_W'(i_frame.b3);

    assign pop     = i_q_valid && (!r_valid || i_ready);
    assign o_pop   = pop;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            o_descriptor     <= i_frame.descriptor;
            o_payload_length <= i_frame.length;
            o_payload_b0     <= i_frame.b0;
            o_payload_b1     <= i_frame.b1;
            o_payload_b2     <= i_frame.b2;
            o_payload_b3     <= i_frame.b3;
            o_gain_scaled    <= gain;
            o_gain_kind      <= i_frame.kind;
        end
    end

    a_pop_fills : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_valid)
        else $error("popped word did not reach the output register");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !pop)
        else $error("output word overwritten while stalled");

endmodule

### rtl/core/length_framed_command_parser_top.sv
// length_framed_command_parser_top: parser front, frame queue and gain back end
// depends on lfcp_pkg, lfcp_front, lfcp_queue and lfcp_back
//
//   channel   direction   handshake            payload
//   rx        in          i_valid / o_ready    i_rx_byte
//   frame     out         o_valid / i_ready    o_descriptor .. o_gain_kind
//
// one received word is taken every cycle while the two-entry frame queue has room
// a finished frame reaches o_valid after its end mark through the queue, then the
// output register that also forms the gain
// the gain sum uses constant weights only, one adder tree before the output register
// reset is synchronous, active low, and clears parser, resync detector, output valid and queue
// a stalled output fills the queue; o_ready drops only when the queue is full
module length_framed_command_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_descriptor,
    output logic [15:0] o_payload_length,
    output logic [7:0]  o_payload_b0,
    output logic [7:0]  o_payload_b1,
    output logic [7:0]  o_payload_b2,
    output logic [7:0]  o_payload_b3,
    output logic [18:0] o_gain_scaled,
    output logic [1:0]  o_gain_kind
);

    lfcp_pkg::t_frame push_frame;
    lfcp_pkg::t_frame head_frame;
    logic             push;
    logic             full;
    logic             pop;
    logic             q_valid;

    lfcp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_full    (full),
        .o_push    (push),
        .o_frame   (push_frame)
    );

    lfcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_frame (head_frame)
    );

    lfcp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_frame          (head_frame),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_descriptor     (o_descriptor),
        .o_payload_length (o_payload_length),
        .o_payload_b0     (o_payload_b0),
        .o_payload_b1     (o_payload_b1),
        .o_payload_b2     (o_payload_b2),
        .o_payload_b3     (o_payload_b3),
        .o_gain_scaled    (o_gain_scaled),
        .o_gain_kind      (o_gain_kind)
    );

endmodule

### sim/tb_top.sv
// tb_top: self-checking bench for length_framed_command_parser_top
// depends on lfcp_pkg and the rtl of the block; drives words through a frame predictor
// directed frames first, then random frames, noise and resyncs with random idling on both sides
module tb_top;

    localparam int RANDOM_WORDS = 650;

    typedef struct packed {
        logic [7:0]           descriptor;
        logic [15:0]          length;
        logic [7:0]           b0;
        logic [7:0]           b1;
        logic [7:0]           b2;
        logic [7:0]           b3;
        logic [18:0]          gain;
        lfcp_pkg::t_gain_kind kind;
    } t_frame_rec;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        t_frame_rec want;
    } t_dir_row;

    typedef enum logic [2:0] {
        HUNT_GT, WANT_STAR, WANT_GT, LEN_LO, LEN_HI, DESC_BYTE, PAYLOAD
    } t_hdr_phase;

    typedef enum logic [1:0] {SYNC_IDLE, SYNC_LT, SYNC_HASH} t_sync_phase;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOKED} t_rx_mode;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_ready   = 1'b0;
    logic [7:0]  o_descriptor;
    logic [15:0] o_payload_length;
    logic [7:0]  o_payload_b0;
    logic [7:0]  o_payload_b1;
    logic [7:0]  o_payload_b2;
    logic [7:0]  o_payload_b3;
    logic [18:0] o_gain_scaled;
    logic [1:0]  o_gain_kind;

    length_framed_command_parser_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_descriptor     (o_descriptor),
        .o_payload_length (o_payload_length),
        .o_payload_b0     (o_payload_b0),
        .o_payload_b1     (o_payload_b1),
        .o_payload_b2     (o_payload_b2),
        .o_payload_b3     (o_payload_b3),
        .o_gain_scaled    (o_gain_scaled),
        .o_gain_kind      (o_gain_kind)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("length_framed_command_parser_top test failed");
        $finish;
    end

    // frame predictor state
    t_hdr_phase  hdr_phase  = HUNT_GT;
    t_sync_phase sync_phase = SYNC_IDLE;
    logic [7:0]  len_lo     = '0;
    logic [15:0] len_total  = '0;
    logic [7:0]  desc_held  = '0;
    logic [15:0] got_count  = '0;
    logic [7:0]  held [lfcp_pkg::KEPT_BYTES] = '{default: '0};

    t_frame_rec frames_due [$];
    int unsigned n_words            = 0;
    int unsigned n_frames_predicted = 0;
    int unsigned n_frames_checked   = 0;
    int unsigned n_resyncs          = 0;
    int unsigned n_errors           = 0;
    int unsigned burst_left         = 0;

    // directed words: frame with '#' inside the payload and a stray word before the end mark,
    // a resync pattern straddling that end mark, an empty frame, then a 65535 length frame
    // that a resync drops
    t_dir_row dir_rows [29] = '{
        '{lfcp_pkg::CH_GT, 1'b0, '0}, '{lfcp_pkg::CH_STAR, 1'b0, '0},
        '{lfcp_pkg::CH_GT, 1'b0, '0},
        '{8'h04, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{lfcp_pkg::DESC_P, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{lfcp_pkg::CH_HASH, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{lfcp_pkg::CH_LT, 1'b0, '0},
        '{lfcp_pkg::CH_HASH, 1'b1, '{lfcp_pkg::DESC_P, 16'd4, 8'hFF, 8'hFF,
                                     lfcp_pkg::CH_HASH, 8'hFF, 19'd281105,
                                     lfcp_pkg::KIND_P}},
        '{lfcp_pkg::CH_LT, 1'b0, '0},
        '{lfcp_pkg::CH_GT, 1'b0, '0}, '{lfcp_pkg::CH_STAR, 1'b0, '0},
        '{lfcp_pkg::CH_GT, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{lfcp_pkg::DESC_LP, 1'b0, '0},
        '{lfcp_pkg::CH_HASH, 1'b1, '{lfcp_pkg::DESC_LP, 16'd0, 8'h00, 8'h00,
                                     8'h00, 8'h00, 19'd0, lfcp_pkg::KIND_LP}},
        '{lfcp_pkg::CH_GT, 1'b0, '0}, '{lfcp_pkg::CH_STAR, 1'b0, '0},
        '{lfcp_pkg::CH_GT, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{lfcp_pkg::DESC_D, 1'b0, '0},
        '{lfcp_pkg::CH_LT, 1'b0, '0}, '{lfcp_pkg::CH_HASH, 1'b0, '0},
        '{lfcp_pkg::CH_LT, 1'b0, '0}
    };

    function automatic void drop_frame();
        hdr_phase = HUNT_GT;
        len_lo    = '0;
        len_total = '0;
        desc_held = '0;
        got_count = '0;
        foreach (held[k]) held[k] = '0;
    endfunction

    function automatic bit parse_word(input logic [7:0] b, output t_frame_rec fr);
        int unsigned sum;
        bit          done;
        done = 1'b0;
        fr   = '0;
        // resync runs first and clears the frame before the word reaches the header logic
        case (sync_phase)
            SYNC_LT: sync_phase = (b == lfcp_pkg::CH_HASH) ? SYNC_HASH : SYNC_IDLE;
            SYNC_HASH: begin
                if (b == lfcp_pkg::CH_LT) begin
                    drop_frame();
                    n_resyncs++;
                end
                sync_phase = SYNC_IDLE;
            end
            default: sync_phase = (b == lfcp_pkg::CH_LT) ? SYNC_LT : SYNC_IDLE;
        endcase
        case (hdr_phase)
            WANT_STAR: hdr_phase = (b == lfcp_pkg::CH_STAR) ? WANT_GT : HUNT_GT;
            WANT_GT:   hdr_phase = (b == lfcp_pkg::CH_GT) ? LEN_LO : HUNT_GT;
            LEN_LO: begin
                len_lo    = b;
                hdr_phase = LEN_HI;
            end
            LEN_HI: begin
                len_total = {b, len_lo};
                hdr_phase = DESC_BYTE;
            end
            DESC_BYTE: begin
                desc_held = b;
                got_count = '0;
                hdr_phase = PAYLOAD;
            end
            PAYLOAD: begin
                if (got_count < len_total) begin
                    if (got_count < lfcp_pkg::KEPT_BYTES) held[got_count] = b;
                    got_count++;
                end else if (b == lfcp_pkg::CH_HASH) begin
                    sum = held[0] * 1000 + held[1] * 100 + held[2] * 10 + held[3];
                    fr.descriptor = desc_held;
                    fr.length     = len_total;
                    fr.b0         = held[0];
                    fr.b1         = held[1];
                    fr.b2         = held[2];
                    fr.b3         = held[3];
                    fr.gain       = sum[18:0];
                    if (desc_held == lfcp_pkg::DESC_P)       fr.kind = lfcp_pkg::KIND_P;
                    else if (desc_held == lfcp_pkg::DESC_LP) fr.kind = lfcp_pkg::KIND_LP;
                    else if (desc_held == lfcp_pkg::DESC_D)  fr.kind = lfcp_pkg::KIND_D;
                    else                                     fr.kind = lfcp_pkg::KIND_OTHER;
                    done = 1'b1;
                    drop_frame();
                end
            end
            default: hdr_phase = (b == lfcp_pkg::CH_GT) ? WANT_STAR : HUNT_GT;
        endcase
        return done;
    endfunction

    task automatic send_word(input logic [7:0] b, input bit typed = 1'b0,
                             input t_frame_rec want = '0);
        t_frame_rec  fr;
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 24);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        n_words++;
        burst_left--;
        if (parse_word(b, fr) || typed) begin
            frames_due.push_back(typed ? want : fr);
            n_frames_predicted++;
        end
    endtask

    // hold the sender off until every predicted frame has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (frames_due.size() != 0);
    endtask

    task automatic send_header(input logic [15:0] len, input logic [7:0] desc);
        send_word(lfcp_pkg::CH_GT);
        send_word(lfcp_pkg::CH_STAR);
        send_word(lfcp_pkg::CH_GT);
        send_word(len[7:0]);
        send_word(len[15:8]);
        send_word(desc);
    endtask

    // digit values half the time, so the gain looks like a real setting, with some '#' mixed in
    function automatic logic [7:0] pick_payload();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)       return 8'($urandom_range(0, 9));
        else if (r == 9) return lfcp_pkg::CH_HASH;
        else             return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_noise();
        case ($urandom_range(0, 4))
            0:       return lfcp_pkg::CH_GT;
            1:       return lfcp_pkg::CH_STAR;
            2:       return lfcp_pkg::CH_HASH;
            3:       return lfcp_pkg::CH_LT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // receiver stall pattern, switching mode whenever its random countdown runs out
    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_ready <= 1'b1;
            RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: i_ready <= ($urandom_range(0, 7) != 0);
            default:   i_ready <= ((rx_left % 16) < 4);
        endcase
    end

    always @(posedge i_clk) begin
        t_frame_rec want;
        if (i_rst_n && o_valid && i_ready) begin
            if (frames_due.size() == 0) begin
                $display("%0t: frame out with none pending, descriptor 0x%0h length %0d",
                         $time, o_descriptor, o_payload_length);
                n_errors++;
            end else begin
                want = frames_due.pop_front();
                check_field("descriptor", want.descriptor, o_descriptor);
                check_field("payload_length", want.length, o_payload_length);
                check_field("payload_b0", want.b0, o_payload_b0);
                check_field("payload_b1", want.b1, o_payload_b1);
                check_field("payload_b2", want.b2, o_payload_b2);
                check_field("payload_b3", want.b3, o_payload_b3);
                check_field("gain_scaled", want.gain, o_gain_scaled);
                check_field("gain_kind", want.kind, o_gain_kind);
                n_frames_checked++;
            end
        end
    end

    initial begin
        int unsigned frame_idx;
        int unsigned pick;
        bit          long_done;
        bit          paused;
        logic [15:0] len;
        logic [7:0]  desc;
        logic [7:0]  junk;
        frame_idx = 0;
        long_done = 1'b0;
        paused    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) send_word(dir_rows[k].b, dir_rows[k].typed, dir_rows[k].want);
        wait_drained();

        while (n_words < RANDOM_WORDS) begin
            if (!paused && n_words > 350) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick < 14 || frame_idx < 4) begin
                case ((frame_idx < 4) ? frame_idx : $urandom_range(0, 3))
                    0:       desc = lfcp_pkg::DESC_P;
                    1:       desc = lfcp_pkg::DESC_LP;
                    2:       desc = lfcp_pkg::DESC_D;
                    default: desc = 8'($urandom_range(0, 255));
                endcase
                if (!long_done && n_words > 200) begin
                    len       = 16'h0102;
                    long_done = 1'b1;
                end else if ($urandom_range(0, 5) == 0) begin
                    len = 16'($urandom_range(5, 16));
                end else begin
                    len = 16'($urandom_range(0, 4));
                end
                send_header(len, desc);
                repeat (len) send_word(pick_payload());
                // words after a full payload are ignored until the end mark
                repeat ($urandom_range(0, 2)) begin
                    junk = 8'($urandom_range(0, 255));
                    send_word((junk == lfcp_pkg::CH_HASH) ? 8'h41 : junk);
                end
                send_word(lfcp_pkg::CH_HASH);
                frame_idx++;
            end else if (pick < 16) begin
                // partial frame with any length, then a resync, which drops it unless its payload is complete
                send_header(16'($urandom), 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 3)) send_word(pick_payload());
                send_word(lfcp_pkg::CH_LT);
                send_word(lfcp_pkg::CH_HASH);
                send_word(lfcp_pkg::CH_LT);
            end else if (pick < 18) begin
                repeat ($urandom_range(1, 6)) send_word(pick_noise());
            end else begin
                // broken header
                send_word(lfcp_pkg::CH_GT);
                if ($urandom_range(0, 1) == 1) send_word(lfcp_pkg::CH_STAR);
                send_word(pick_noise());
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("covered %0d words, %0d frames checked, %0d resyncs seen by the predictor",
                 n_words, n_frames_checked, n_resyncs);
        $display("%0d mismatches, %0d frames still pending", n_errors, frames_due.size());
        if (n_errors == 0 && frames_due.size() == 0) begin
            $display("length_framed_command_parser_top test passed");
        end else begin
            $display("length_framed_command_parser_top test failed");
        end
        $finish;
    end

endmodule
